[hdl/upe_pkg.sv]
// Shared types, constants and helpers for the URL percent encoder.
// No dependencies; imported by upe_front, upe_fifo, upe_back and url_percent_encoder.
`default_nettype none

package upe_pkg;

  localparam int unsigned MAX_CAPACITY_DEF = 1024;
  localparam int unsigned CAP_CEIL         = 1024;
  localparam int unsigned CAP_RESET        = 192;
  localparam int unsigned CAP_W            = 11;
  localparam int unsigned LEN_W            = 10;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CTRL_LIMIT   = 8'd32;
  localparam logic [7:0] CHAR_DEL     = 8'd127;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [3:0] NIBBLE_MASK  = 4'd15;

  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_CONTROL  = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_CHAR = 2'd0,
    CMD_ESC  = 2'd1,
    CMD_DONE = 2'd2
  } cmd_kind_e;

  typedef enum logic [1:0] {
    PH_PCT = 2'd0,
    PH_HI  = 2'd1,
    PH_LO  = 2'd2
  } esc_phase_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [7:0]        data;
    status_e           status;
    logic [LEN_W-1:0]  length;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic is_unreserved(input logic [7:0] b);
    logic r;
    r = (b >= 8'h30 && b <= 8'h39) ||
        (b >= 8'h41 && b <= 8'h5a) ||
        (b >= 8'h61 && b <= 8'h7a) ||
        b == 8'h2d || b == 8'h5f || b == 8'h2e || b == 8'h7e;
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/upe_in_if.sv]
// Input channel of the URL percent encoder: one raw byte or a terminator per item.
// No dependencies.
`default_nettype none

interface upe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, in_byte, end_of_string, input ready);
  modport sink   (input valid, in_byte, end_of_string, output ready);
endinterface

`default_nettype wire

[hdl/upe_out_if.sv]
// Output channel of the URL percent encoder: one encoded character or status per item.
// No dependencies.
`default_nettype none

interface upe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       done_res;
  logic [1:0] status;
  logic [9:0] encoded_length;
  logic       last_of_run;

  modport source (output valid, out_char, char_valid, done_res, status, encoded_length,
                  last_of_run, input ready);
  modport sink   (input valid, out_char, char_valid, done_res, status, encoded_length,
                  last_of_run, output ready);
endinterface

`default_nettype wire

[hdl/upe_front.sv]
// Front end: accepts bytes, tracks length and rejection state, queues commands.
// Depends on upe_pkg and upe_in_if.
`default_nettype none

module upe_front
  import upe_pkg::*;
#(
  parameter int unsigned MAX_CAPACITY = MAX_CAPACITY_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i,
  upe_in_if.sink                in_i,
  input  wire fifo_stat_t       q_stat_i,
  output      logic             push_o,
  output      cmd_t             push_cmd_o
);

  localparam int unsigned CAP_LIMIT = (MAX_CAPACITY < CAP_CEIL) ? MAX_CAPACITY : CAP_CEIL;
  localparam int unsigned CAP_INIT  = (CAP_RESET > CAP_LIMIT) ? CAP_LIMIT : CAP_RESET;

  logic [CAP_W-1:0] cap_q, cap_d;
  logic [LEN_W-1:0] used_q, used_d;
  status_e          err_q, err_d;

  logic             accept;
  logic             plain;
  logic [CAP_W-1:0] sum;

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign plain      = is_unreserved(in_i.in_byte);
  assign sum        = {1'b0, used_q} + (plain ? CAP_W'(1) : CAP_W'(3));

  always_comb begin
    cap_d = cap_q;
    if (cfg_we_i) begin
      cap_d = (cfg_wdata_i > CAP_W'(CAP_LIMIT)) ? CAP_W'(CAP_LIMIT) : cfg_wdata_i;
    end
  end

  always_comb begin
    used_d            = used_q;
    err_d             = err_q;
    push_o            = 1'b0;
    push_cmd_o.kind   = plain ? CMD_CHAR : CMD_ESC;
    push_cmd_o.data   = in_i.in_byte;
    push_cmd_o.status = ST_OK;
    push_cmd_o.length = used_q;
    if (accept) begin
      if (in_i.end_of_string) begin
        push_o          = 1'b1;
        push_cmd_o.kind = CMD_DONE;
        if (err_q != ST_OK) begin
          push_cmd_o.status = err_q;
        end else if (used_q == '0) begin
          push_cmd_o.status = ST_EMPTY;
        end
        used_d = '0;
        err_d  = ST_OK;
      end else if (err_q == ST_OK) begin
        if (in_i.in_byte < CTRL_LIMIT || in_i.in_byte == CHAR_DEL) begin
          err_d = ST_CONTROL;
        end else if (sum >= cap_q) begin
          err_d = ST_TOO_LONG;
        end else begin
          used_d = sum[LEN_W-1:0];
          push_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_W'(CAP_INIT);
      used_q <= '0;
      err_q  <= ST_OK;
    end else begin
      cap_q  <= cap_d;
      used_q <= used_d;
      err_q  <= err_d;
    end
  end

endmodule

`default_nettype wire

[hdl/upe_fifo.sv]
// Short command queue between front and back end.
// Depends on upe_pkg.
`default_nettype none

module upe_fifo
  import upe_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire cmd_t  push_cmd_i,
  input  wire logic  pop_i,
  output      cmd_t  head_o,
  output fifo_stat_t stat_o
);

  cmd_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W:0] wr_ptr_q, rd_ptr_q;

  assign head_o       = mem_q[rd_ptr_q[QPTR_W-1:0]];
  assign stat_o.empty = (wr_ptr_q == rd_ptr_q);
  assign stat_o.full  = (wr_ptr_q[QPTR_W-1:0] == rd_ptr_q[QPTR_W-1:0]) &&
                        (wr_ptr_q[QPTR_W] != rd_ptr_q[QPTR_W]);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q[QPTR_W-1:0]] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/upe_back.sv]
// Back end: expands queued commands into output items through an output register.
// Depends on upe_pkg and upe_out_if.
`default_nettype none

module upe_back
  import upe_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cmd_t       head_i,
  input  wire fifo_stat_t q_stat_i,
  output      logic       pop_o,
  upe_out_if.source       out_o
);

  esc_phase_e       phase_q, phase_d;
  logic             ov_q, ov_d;
  logic             load;
  logic             emit;

  logic [7:0]       char_q, char_d;
  logic             cv_q, cv_d;
  logic             done_q, done_d;
  logic [1:0]       stat_q, stat_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             last_q, last_d;

  assign load = !ov_q || out_o.ready;
  assign emit = load && !q_stat_i.empty;

  always_comb begin
    phase_d = phase_q;
    ov_d    = ov_q && !out_o.ready;
    pop_o   = 1'b0;
    char_d  = '0;
    cv_d    = 1'b1;
    done_d  = 1'b0;
    stat_d  = '0;
    len_d   = '0;
    last_d  = 1'b1;
    if (emit) begin
      ov_d = 1'b1;
      unique case (head_i.kind)
        CMD_CHAR: begin
          char_d = head_i.data;
          pop_o  = 1'b1;
        end
        CMD_ESC: begin
          unique case (phase_q)
            PH_PCT: begin
              char_d  = CHAR_PERCENT;
              last_d  = 1'b0;
              phase_d = PH_HI;
            end
            PH_HI: begin
              char_d  = HEX_DIGITS[head_i.data[7:4]];
              last_d  = 1'b0;
              phase_d = PH_LO;
            end
            default: begin
              char_d  = HEX_DIGITS[head_i.data[3:0] & NIBBLE_MASK];
              pop_o   = 1'b1;
              phase_d = PH_PCT;
            end
          endcase
        end
        default: begin
          cv_d   = 1'b0;
          done_d = 1'b1;
          stat_d = head_i.status;
          len_d  = head_i.length;
          pop_o  = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q    <= 1'b0;
      phase_q <= PH_PCT;
    end else begin
      ov_q    <= ov_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      char_q <= char_d;
      cv_q   <= cv_d;
      done_q <= done_d;
      stat_q <= stat_d;
      len_q  <= len_d;
      last_q <= last_d;
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.out_char       = char_q;
  assign out_o.char_valid     = cv_q;
  assign out_o.done_res       = done_q;
  assign out_o.status         = stat_q;
  assign out_o.encoded_length = len_q;
  assign out_o.last_of_run    = last_q;

endmodule

`default_nettype wire

[hdl/url_percent_encoder.sv]
// URL percent encoder top level: front end, command queue and back end.
// Depends on upe_pkg, upe_in_if, upe_out_if, upe_front, upe_fifo and upe_back.
//
// Streams a query string one byte per item and percent-encodes it; letters, digits
// and - _ . ~ pass through, any other byte becomes '%' and two upper-case hex digits.
// A control byte or an encoded length reaching the capacity register rejects the
// string; the terminator item returns status and length and starts a new string.
// The input takes one item per cycle while the four-entry command queue has room.
// The back end emits one item per cycle from its output register while the receiver
// is ready, so a plain byte or a terminator becomes one item, an escaped byte three;
// sustained rate is bounded by that output sequencer. Rejected bytes are taken and
// produce nothing. Capacity may only be written while the block is idle.
`default_nettype none

module url_percent_encoder
  import upe_pkg::*;
#(
  parameter int unsigned MAX_CAPACITY = MAX_CAPACITY_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i,
  upe_in_if.sink                in_i,
  upe_out_if.source             out_o
);

  logic       push;
  cmd_t       push_cmd;
  logic       pop;
  cmd_t       head;
  fifo_stat_t q_stat;

  upe_front #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_cmd_o  (push_cmd)
  );

  upe_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  upe_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_stat.full))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && q_stat.empty))
    else $error("command queue underflow");

  a_done_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.done_res |->
      !out_o.char_valid && out_o.last_of_run && out_o.out_char == 8'd0)
    else $error("malformed status item");

  a_char_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.done_res |->
      out_o.char_valid && out_o.status == 2'd0 && out_o.encoded_length == 10'd0)
    else $error("malformed character item");

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for url_percent_encoder: directed and random byte strings
// under several capacities and handshake patterns, checked item by item.
// Depends on upe_pkg, upe_in_if, upe_out_if and url_percent_encoder.
`default_nettype none

module tb_top
  import upe_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]       ch;
    logic             ch_valid;
    logic             done;
    status_e          st;
    logic [LEN_W-1:0] len;
    logic             last;
  } enc_result_t;

  class encode_scoreboard;
    logic [CAP_W-1:0] capacity;
    logic [LEN_W-1:0] used;
    status_e          reject;
    enc_result_t      expected_q[$];
    int               errors;

    function new();
      capacity = CAP_RESET;
      used     = '0;
      reject   = ST_OK;
      errors   = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] v);
      capacity = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit passes_through(logic [7:0] b);
      return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
             b == "-" || b == "_" || b == "." || b == "~";
    endfunction

    function logic [7:0] hex_char(logic [3:0] nib);
      return (nib < 4'd10) ? 8'h30 + nib : 8'h37 + nib;
    endfunction

    function void push_char(logic [7:0] c, logic last);
      enc_result_t r;
      r = '0;
      r.ch = c;
      r.ch_valid = 1'b1;
      r.st = ST_OK;
      r.last = last;
      expected_q.push_back(r);
    endfunction

    function void note_item(logic [7:0] b, logic eos);
      enc_result_t r;
      int          limit;
      int          needed;
      if (eos) begin
        r = '0;
        r.done = 1'b1;
        r.st = (reject != ST_OK) ? reject : (used == 0) ? ST_EMPTY : ST_OK;
        r.len = used;
        r.last = 1'b1;
        expected_q.push_back(r);
        used = '0;
        reject = ST_OK;
        return;
      end
      if (reject != ST_OK) return;
      if (b < CTRL_LIMIT || b == CHAR_DEL) begin
        reject = ST_CONTROL;
        return;
      end
      limit = capacity;
      if (limit > MAX_CAPACITY_DEF) limit = MAX_CAPACITY_DEF;
      if (limit > CAP_CEIL) limit = CAP_CEIL;
      needed = passes_through(b) ? 1 : 3;
      if (int'(used) + needed >= limit) begin
        reject = ST_TOO_LONG;
        return;
      end
      used = used + LEN_W'(needed);
      if (needed == 1) begin
        push_char(b, 1'b1);
      end else begin
        push_char(CHAR_PERCENT, 1'b0);
        push_char(hex_char(b[7:4]), 1'b0);
        push_char(hex_char(b[3:0]), 1'b1);
      end
    endfunction

    function void check_result(enc_result_t got);
      enc_result_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item char=%h cv=%b done=%b st=%0d len=%0d last=%b",
                 $time, got.ch, got.ch_valid, got.done, got.st, got.len, got.last);
        return;
      end
      exp = expected_q.pop_front();
      if (got != exp) begin
        errors++;
        $display("%0t: mismatch expected char=%h cv=%b done=%b st=%0d len=%0d last=%b",
                 $time, exp.ch, exp.ch_valid, exp.done, exp.st, exp.len, exp.last);
        $display("%0t:          actual   char=%h cv=%b done=%b st=%0d len=%0d last=%b",
                 $time, got.ch, got.ch_valid, got.done, got.st, got.len, got.last);
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  upe_in_if  in_ch ();
  upe_out_if out_ch ();

  url_percent_encoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  encode_scoreboard sb = new();
  int    src_idle_pct = 0;
  int    snk_stall_pct = 0;
  int    hold_left = 0;
  string plain_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_.~";

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("url_percent_encoder regression: fail");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      sb.note_item(in_ch.in_byte, in_ch.end_of_string);
    end
  end

  always @(posedge clk_i) begin
    enc_result_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.ch       = out_ch.out_char;
      got.ch_valid = out_ch.char_valid;
      got.done     = out_ch.done_res;
      got.st       = status_e'(out_ch.status);
      got.len      = out_ch.encoded_length;
      got.last     = out_ch.last_of_run;
      sb.check_result(got);
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.in_byte <= 8'($urandom);
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.end_of_string <= eos;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_item(s[k], 1'b0);
  endtask

  task automatic finish_string();
    send_item(8'($urandom), 1'b1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_capacity(v);
  endtask

  function automatic logic [7:0] pick_byte(bit dirty);
    int r;
    r = $urandom_range(99);
    if (dirty && r < 8) return ($urandom_range(1) == 0) ? 8'($urandom_range(31)) : CHAR_DEL;
    if (r < 45) return plain_set[$urandom_range(plain_set.len() - 1)];
    if (r < 75) return 8'($urandom_range(8'h7e, 8'h20));
    if (r < 95) return 8'($urandom_range(8'hff, 8'h80));
    return 8'($urandom_range(255));
  endfunction

  task automatic send_string(input int max_len, input int dirty_pct);
    int n;
    bit dirty;
    n = $urandom_range(max_len);
    dirty = ($urandom_range(99) < dirty_pct);
    for (int k = 0; k < n; k++) send_item(pick_byte(dirty), 1'b0);
    finish_string();
  endtask

  task automatic run_phase(input int src_pct, input int snk_pct, input logic [CAP_W-1:0] cap,
                           input int strings);
    write_capacity(cap);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    repeat (strings) send_string(10, 15);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.end_of_string <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset capacity: empty string, pass-through and escapes, control rejections
    finish_string();
    send_text("azAZ09-_.~ /@[`{");
    send_item(8'h80, 1'b0);
    send_item(8'hff, 1'b0);
    finish_string();
    send_item(CHAR_DEL, 1'b0);
    send_item("a", 1'b0);
    finish_string();
    send_item("b", 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h1f, 1'b0);
    finish_string();

    // capacities zero and one reject everything; a small one rejects mid-string
    write_capacity(11'd0);
    send_item("a", 1'b0);
    finish_string();
    write_capacity(11'd1);
    send_item(" ", 1'b0);
    finish_string();
    write_capacity(11'd5);
    send_text("ab ");
    finish_string();
    send_text("a ");
    finish_string();

    // register above the ceiling acts as the ceiling
    write_capacity(11'h7ff);
    for (int k = 0; k < 12; k++) send_item(8'($urandom_range(8'hff, 8'h80)), 1'b0);
    finish_string();

    run_phase(0, 0, 11'd1024, 3);
    run_phase(48, 0, 11'd24, 3);
    run_phase(0, 48, 11'd2, 3);
    run_phase(17, 17, 11'd192, 3);
    run_phase(0, 0, 11'd13, 3);

    // long receiver hold-off while items keep coming, then a full pause
    write_capacity(11'd192);
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_left = 120;
    for (int k = 0; k < 12; k++) send_item(8'($urandom_range(8'hff, 8'h80)), 1'b0);
    finish_string();
    drain();
    send_string(10, 0);

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("url_percent_encoder regression: pass");
    end else begin
      $display("url_percent_encoder regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hdl/upe_pkg.sv
hdl/upe_in_if.sv
hdl/upe_out_if.sv
hdl/upe_front.sv
hdl/upe_fifo.sv
hdl/upe_back.sv
hdl/url_percent_encoder.sv
test/tb_top.sv
